// ===== hw/rtl/mfmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared types and constants for the multi-turn feedback decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

   localparam int unsigned IdWidth       = 11;
   localparam int unsigned DeadbandWidth = 15;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 15;
   localparam int unsigned ReqDataWidth  = 104;
   localparam int unsigned RspDataWidth  = 88;

   localparam logic [CsrIndexWidth-1:0] CsrMotorId  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrDeadband = 1'b1;

   localparam logic [IdWidth-1:0]       MotorIdReset  = 11'd513;
   localparam logic [DeadbandWidth-1:0] DeadbandReset = 15'd5;

   localparam logic ActFrame     = 1'b0;
   localparam logic ActCalibrate = 1'b1;

   typedef struct packed {
      logic               action;
      logic [IdWidth-1:0] frame_id;
      logic [15:0]        angle;
      logic [15:0]        speed;
      logic [15:0]        current;
      logic [7:0]         temp;
      logic [31:0]        calib_position;
   } req_item_type;

   typedef struct packed {
      logic        matched;
      logic [15:0] rotor_angle;
      logic [15:0] rotor_speed;
      logic [15:0] rotor_current;
      logic [7:0]  rotor_temp;
      logic [31:0] absolute_angle;
   } rsp_item_type;

   typedef struct packed {
      logic [IdWidth-1:0]       motor_id;
      logic [DeadbandWidth-1:0] speed_deadband;
   } cfg_type;

endpackage

// ===== hw/rtl/motor_feedback_multiturn_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_top
// Feedback frame decoder with multi-turn angle tracking and calibration.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, then the result register; the
//   state update sits between the two.
// Throughput: one transfer per cycle; bounded only by rsp_tready.
// Reset: synchronous; clears both stages, held values, count and seed flag,
//   and restores motor_id to 513 and speed_deadband to 5.
module motor_feedback_multiturn_decoder_top import mfmd_pkg::*; #(
   parameter int unsigned COUNTS_PER_REV = 8192
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6, calib_position
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // action
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rotor_angle, rotor_speed, rotor_current, rotor_temp, absolute_angle
   output logic [RspDataWidth-1:0]  rsp_tdata,
   // matched
   output logic                     rsp_tuser,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type      cfg_ff;
   logic         s1_valid_ff;
   req_item_type s1_item_ff, s1_item_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         advance;

   always_comb begin
      s1_item_in.action         = req_tuser;
      s1_item_in.frame_id       = req_tdata[10:0];
      s1_item_in.angle          = {req_tdata[18:11], req_tdata[26:19]};
      s1_item_in.speed          = {req_tdata[34:27], req_tdata[42:35]};
      s1_item_in.current        = {req_tdata[50:43], req_tdata[58:51]};
      s1_item_in.temp           = req_tdata[66:59];
      s1_item_in.calib_position = req_tdata[98:67];
   end

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   mfmd_track #(
      .COUNTS_PER_REV(COUNTS_PER_REV)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .result(rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_id       <= MotorIdReset;
         cfg_ff.speed_deadband <= DeadbandReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrMotorId: begin
               cfg_ff.motor_id <= csr_wdata[IdWidth-1:0];
            end
            CsrDeadband: begin
               cfg_ff.speed_deadband <= csr_wdata[DeadbandWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // result stage: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.matched;
   assign rsp_tdata  = {rsp_item_ff.absolute_angle, rsp_item_ff.rotor_temp,
                        rsp_item_ff.rotor_current, rsp_item_ff.rotor_speed,
                        rsp_item_ff.rotor_angle};

endmodule

// ===== hw/rtl/mfmd_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_track
// Held feedback values and multi-turn count, with their combinational update.
// ----------------------------------------------------------------------------
module mfmd_track import mfmd_pkg::*; #(
   parameter int unsigned COUNTS_PER_REV = 8192
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam logic signed [16:0] HalfRev = 17'(COUNTS_PER_REV / 2);
   localparam logic [31:0]        RevW    = 32'(COUNTS_PER_REV);

   logic [15:0] prev_angle_ff, prev_angle_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [31:0] turn_ff, turn_in;
   logic [15:0] angle_ff, angle_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] current_ff, current_in;
   logic [7:0]  temp_ff, temp_in;

   logic               hit;
   logic [15:0]        base;
   logic [15:0]        diff;
   logic signed [16:0] diff_s;
   logic [15:0]        mag;
   logic               moving;
   logic [31:0]        corr;
   logic [31:0]        stepped;

   assign hit    = (item.action == ActFrame) && (item.frame_id == cfg.motor_id);
   assign base   = prev_valid_ff ? prev_angle_ff : item.angle;
   assign diff   = item.angle - base;
   assign diff_s = signed'({diff[15], diff});
   assign mag    = item.speed[15] ? (~item.speed + 16'd1) : item.speed;
   assign moving = mag > {1'b0, cfg.speed_deadband};

   always_comb begin
      if (diff_s < -HalfRev) begin
         corr = RevW;
      end else if (diff_s > HalfRev) begin
         corr = ~RevW + 32'd1;
      end else begin
         corr = 32'd0;
      end
   end

   assign stepped = turn_ff + {{16{diff[15]}}, diff} + corr;

   always_comb begin
      prev_angle_in = prev_angle_ff;
      prev_valid_in = prev_valid_ff;
      turn_in       = turn_ff;
      angle_in      = angle_ff;
      speed_in      = speed_ff;
      current_in    = current_ff;
      temp_in       = temp_ff;
      if (item.action == ActCalibrate) begin
         turn_in       = item.calib_position;
         prev_valid_in = 1'b0;
      end else if (hit) begin
         angle_in      = item.angle;
         speed_in      = item.speed;
         current_in    = item.current;
         temp_in       = item.temp;
         prev_angle_in = item.angle;
         prev_valid_in = 1'b1;
         if (moving) begin
            turn_in = stepped;
         end
      end
   end

   always_comb begin
      result.matched        = hit;
      result.rotor_angle    = angle_in;
      result.rotor_speed    = speed_in;
      result.rotor_current  = current_in;
      result.rotor_temp     = temp_in;
      result.absolute_angle = turn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= '0;
         prev_valid_ff <= 1'b0;
         turn_ff       <= '0;
         angle_ff      <= '0;
         speed_ff      <= '0;
         current_ff    <= '0;
         temp_ff       <= '0;
      end else if (fire) begin
         prev_angle_ff <= prev_angle_in;
         prev_valid_ff <= prev_valid_in;
         turn_ff       <= turn_in;
         angle_ff      <= angle_in;
         speed_ff      <= speed_in;
         current_ff    <= current_in;
         temp_ff       <= temp_in;
      end
   end

endmodule

// ===== hw/rtl/mfmd_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_check
// Port-level checks for the multi-turn feedback decoder.
// ----------------------------------------------------------------------------
module mfmd_check import mfmd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [ReqDataWidth-1:0] req_tdata,
   input logic                    req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // calibrate transfer loads the count and never reports a match
   a_calibrate: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) ##1 rsp_tready
      |=> rsp_tvalid && !rsp_tuser && rsp_tdata[87:56] == $past(req_tdata[98:67], 2))
      else $error("calibration not reflected in result");

   // matched frame shows its own angle
   a_match_angle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser) ##1 rsp_tready
      |=> rsp_tvalid
          && (!rsp_tuser
              || rsp_tdata[15:0] == $past({req_tdata[18:11], req_tdata[26:19]}, 2)))
      else $error("matched result angle differs from frame");

endmodule

bind motor_feedback_multiturn_decoder_top mfmd_check u_mfmd_check (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

// ===== sim/motor_feedback_multiturn_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_top_tb
// Drives feedback frames and calibrate commands into the multi-turn decoder
// under random source gaps and sink stalls, and across several motor_id and
// deadband settings. A tracker class keeps its own copy of the decoder state,
// predicts every result and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder_top_tb import mfmd_pkg::*; ();

   localparam int CountsPerRev = 8192;
   localparam int PhaseItems   = 170;

   class multiturn_tracker;
      logic [IdWidth-1:0]       motor_id;
      logic [DeadbandWidth-1:0] deadband;
      logic [15:0]              prior_angle;
      bit                       seeded;
      logic [31:0]              count;
      logic [15:0]              held_angle;
      logic [15:0]              held_speed;
      logic [15:0]              held_current;
      logic [7:0]               held_temp;
      rsp_item_type             expected_q[$];
      int                       error_count;

      function new();
         motor_id     = MotorIdReset;
         deadband     = DeadbandReset;
         prior_angle  = '0;
         seeded       = 1'b0;
         count        = '0;
         held_angle   = '0;
         held_speed   = '0;
         held_current = '0;
         held_temp    = '0;
         error_count  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void absorb(req_item_type r);
         rsp_item_type want;
         logic [15:0]  delta;
         int           spd;
         int           mag;
         int           d;
         want.matched = 1'b0;
         if (r.action == ActCalibrate) begin
            count  = r.calib_position;
            seeded = 1'b0;
         end else if (r.frame_id == motor_id) begin
            want.matched = 1'b1;
            held_angle   = r.angle;
            held_speed   = r.speed;
            held_current = r.current;
            held_temp    = r.temp;
            if (!seeded) begin
               prior_angle = r.angle;
               seeded      = 1'b1;
            end
            spd = int'($signed(r.speed));
            mag = (spd < 0) ? -spd : spd;
            if (mag > int'(deadband)) begin
               delta = r.angle - prior_angle;
               d     = int'($signed(delta));
               count = count + 32'(d);
               if (d < -(CountsPerRev / 2)) begin
                  count = count + 32'(CountsPerRev);
               end else if (d > CountsPerRev / 2) begin
                  count = count - 32'(CountsPerRev);
               end
            end
            prior_angle = r.angle;
         end
         want.rotor_angle    = held_angle;
         want.rotor_speed    = held_speed;
         want.rotor_current  = held_current;
         want.rotor_temp     = held_temp;
         want.absolute_angle = count;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(logic matched, logic [RspDataWidth-1:0] data);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing outstanding");
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("matched", 32'(want.matched), 32'(matched));
         compare_field("rotor_angle", 32'(want.rotor_angle), 32'(data[15:0]));
         compare_field("rotor_speed", 32'(want.rotor_speed), 32'(data[31:16]));
         compare_field("rotor_current", 32'(want.rotor_current), 32'(data[47:32]));
         compare_field("rotor_temp", 32'(want.rotor_temp), 32'(data[55:48]));
         compare_field("absolute_angle", want.absolute_angle, data[87:56]);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   multiturn_tracker tracker = new();
   bit               steady_flow;
   logic [15:0]      walk_angle;

   motor_feedback_multiturn_decoder_top #(
      .COUNTS_PER_REV(CountsPerRev)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // result sink: random stall before each transfer, none while steady_flow is set
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady_flow ? 0 : int'($urandom_range(0, 6));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_request(req_item_type r);
      int gap;
      gap = steady_flow ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {5'b0, r.calib_position, r.temp, r.current[7:0], r.current[15:8],
                     r.speed[7:0], r.speed[15:8], r.angle[7:0], r.angle[15:8], r.frame_id};
      do @(posedge clock); while (!req_tready);
      tracker.absorb(r);
   endtask

   // hold the source until every outstanding result has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [IdWidth-1:0] id, logic [DeadbandWidth-1:0] band);
      csr_we    <= 1'b1;
      csr_index <= CsrMotorId;
      csr_wdata <= CsrDataWidth'(id);
      @(posedge clock);
      csr_index <= CsrDeadband;
      csr_wdata <= band;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.motor_id = id;
      tracker.deadband = band;
   endtask

   function automatic req_item_type make_frame(logic [IdWidth-1:0] id, logic [15:0] angle,
                                               logic [15:0] speed, logic [15:0] current,
                                               logic [7:0] temp);
      req_item_type r;
      r.action         = ActFrame;
      r.frame_id       = id;
      r.angle          = angle;
      r.speed          = speed;
      r.current        = current;
      r.temp           = temp;
      r.calib_position = $urandom();
      return r;
   endfunction

   function automatic req_item_type make_calib(logic [31:0] pos);
      req_item_type r;
      r.action         = ActCalibrate;
      r.frame_id       = 11'($urandom_range(0, 2047));
      r.angle          = 16'($urandom());
      r.speed          = 16'($urandom());
      r.current        = 16'($urandom());
      r.temp           = 8'($urandom());
      r.calib_position = pos;
      return r;
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int           sel;
      int           step;
      int           mag;
      logic [15:0]  speed;
      sel = int'($urandom_range(0, 99));
      if (sel < 8) begin
         case ($urandom_range(0, 2))
            0: return make_calib($urandom());
            1: return make_calib({16'h7FFF, 16'($urandom())});
            default: return make_calib({16'h8000, 16'($urandom())});
         endcase
      end
      if (sel < 22) begin
         return make_frame(11'($urandom_range(0, 2047)), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 8'($urandom()));
      end
      sel = int'($urandom_range(0, 99));
      if (sel < 55) begin
         step = int'($urandom_range(0, 1200)) - 600;
      end else if (sel < 85) begin
         step = (($urandom_range(0, 1) != 0) ? 4096 : 8192) - 6
                + int'($urandom_range(0, 12));
         if ($urandom_range(0, 1)) step = -step;
      end else begin
         step = int'($urandom());
      end
      walk_angle = walk_angle + 16'(step);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: speed = 16'($urandom());
         4:          speed = 16'h8000;
         5:          speed = 16'h0000;
         default: begin
            mag   = int'(tracker.deadband) + int'($urandom_range(0, 1));
            speed = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
         end
      endcase
      return make_frame(tracker.motor_id, walk_angle, speed, 16'($urandom()),
                        8'($urandom()));
   endfunction

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CsrMotorId;
      csr_wdata  <= '0;
      steady_flow = 1'b0;
      walk_angle  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_frame(MotorIdReset, 16'h0000, 16'd100, 16'h0000, 8'h00));
      send_request(make_frame(11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(make_frame(MotorIdReset, 16'h1000, 16'd100, 16'h7FFF, 8'h01));
      send_request(make_frame(MotorIdReset, 16'h3001, 16'd100, 16'h8000, 8'h80));
      send_request(make_frame(MotorIdReset, 16'h0000, 16'hFF9C, 16'h0001, 8'h7F));
      send_request(make_frame(MotorIdReset, 16'hFFFF, 16'h8000, 16'hFFFF, 8'hFF));
      send_request(make_frame(MotorIdReset, 16'h7FFF, 16'd5, 16'h1234, 8'h40));
      send_request(make_frame(MotorIdReset, 16'h7FF0, 16'hFFFA, 16'h5678, 8'h41));
      send_request(make_frame(MotorIdReset, 16'h0000, 16'h7FFF, 16'h9ABC, 8'h42));
      send_request(make_frame(MotorIdReset, 16'h8000, 16'h7FFF, 16'hDEF0, 8'h43));
      send_request(make_frame(MotorIdReset, 16'h9001, 16'h7FFF, 16'h0F0F, 8'h44));
      send_request(make_frame(MotorIdReset, 16'h8001, 16'hFFFB, 16'hF0F0, 8'h45));
      send_request(make_calib(32'h7FFF_FFF0));
      send_request(make_frame(MotorIdReset, 16'h1234, 16'h8000, 16'h0000, 8'h46));
      send_request(make_frame(MotorIdReset, 16'h1334, 16'h0100, 16'h0000, 8'h47));
      send_request(make_calib(32'h8000_0005));
      send_request(make_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(make_frame(MotorIdReset, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(make_frame(MotorIdReset, 16'hFF00, 16'hFFFF, 16'hAAAA, 8'hAA));
      send_request(make_frame(MotorIdReset, 16'hFE00, 16'h8000, 16'h5555, 8'h55));
      send_request(make_calib(32'h0000_0000));
      send_request(make_calib(32'hFFFF_FFFF));

      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: configure(11'd0, 15'd0);
               2: configure(11'h7FF, 15'h7FFF);
               3: configure(11'($urandom_range(0, 2047)), 15'($urandom_range(0, 300)));
               default: configure(11'($urandom_range(0, 2047)),
                                  15'($urandom_range(0, 3000)));
            endcase
         end
         for (int i = 0; i < PhaseItems; i++) begin
            if (i % 40 == 0) steady_flow = ($urandom_range(0, 4) == 0);
            if (p == 0 && i == PhaseItems / 2) settle();
            send_request(random_request());
         end
      end

      settle();
      if (tracker.error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mfmd_pkg.sv
hw/rtl/mfmd_track.sv
hw/rtl/motor_feedback_multiturn_decoder_top.sv
hw/rtl/mfmd_check.sv
sim/motor_feedback_multiturn_decoder_top_tb.sv
